### rtl/rra_pkg.sv
// Shared types and constants for the ring resource arbiter.
`timescale 1ns / 1ps
`default_nettype none
package rra_pkg;

	localparam int MAX_SEATS = 16;
	localparam int SEAT_W    = 4;
	localparam int FUNC_W    = 2;
	localparam int WAIT_W    = 32;
	localparam int MEAL_W    = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 32;

	localparam logic [FUNC_W-1:0] FN_TICK    = 2'd0;
	localparam logic [FUNC_W-1:0] FN_REQUEST = 2'd1;
	localparam logic [FUNC_W-1:0] FN_RELEASE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MEAL_LIMIT  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STARV_THRSH = 1'd1;

	localparam logic [MEAL_W-1:0] MEAL_LIMIT_RST  = 16'd5;
	localparam logic [WAIT_W-1:0] STARV_THRSH_RST = 32'd300;
	localparam logic [MEAL_W-1:0] MEAL_MAX        = 16'hFFFF;
	localparam logic [WAIT_W-1:0] WAIT_MAX        = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [SEAT_W-1:0] seat;
	} rra_in_t;

	typedef struct packed {
		logic [MAX_SEATS-1:0] grant_mask;
		logic                 done_res;
		logic [MEAL_W-1:0]    meals_total;
	} rra_out_t;

	typedef struct packed {
		logic [MEAL_W-1:0] meal_limit;
		logic [WAIT_W-1:0] starv_thrsh;
	} rra_cfg_t;

endpackage
`default_nettype wire

### rtl/ring_resource_arbiter_aging.sv
// An accepted item moves from the input stage register to the result register.
// Throughput: one item per cycle unless the output stalls; each event is evaluated
// combinationally between the input stage and result registers, and the seat state updates then.
// Reset (arst_n low, asynchronous): all seats thinking, waits and meal count zero,
// done cleared, meal_limit 5, starvation_threshold 300, both stages empty.
// Top level of the ring resource arbiter with aging.
`timescale 1ns / 1ps
`default_nettype none
module ring_resource_arbiter_aging
	import rra_pkg::*;
#(
	parameter int NUM_SEATS = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire rra_in_t              in_item,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output rra_out_t                  out_item,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data
);

	rra_in_t  item_s1;
	logic     valid_s1;
	rra_out_t out_q;
	logic     out_valid_q;
	rra_cfg_t cfg_q;
	rra_out_t result;
	logic     advance;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.meal_limit  <= MEAL_LIMIT_RST;
			cfg_q.starv_thrsh <= STARV_THRSH_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MEAL_LIMIT:  cfg_q.meal_limit  <= cfg_data[MEAL_W-1:0];
				CFG_STARV_THRSH: cfg_q.starv_thrsh <= cfg_data[WAIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
		if (advance) begin
			out_q <= result;
		end
	end

	rra_core #(
		.NUM_SEATS(NUM_SEATS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result)
	);

endmodule
`default_nettype wire

### rtl/rra_core.sv
// Seat state registers and the combinational event evaluation for the ring.
`timescale 1ns / 1ps
`default_nettype none
module rra_core
	import rra_pkg::*;
#(
	parameter int NUM_SEATS = 8
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     step,
	input  wire rra_in_t  item,
	input  wire rra_cfg_t cfg,
	output rra_out_t      result
);

	logic [NUM_SEATS-1:0] hung_q, eat_q;
	logic [WAIT_W-1:0]    wait_q [NUM_SEATS];
	logic [MEAL_W-1:0]    meal_q;
	logic                 fin_q;

	logic [NUM_SEATS-1:0] seat_oh, left_oh, right_oh;
	logic [NUM_SEATS-1:0] hung0, eat0, hung1, eat1, hung_n, eat_n;
	logic [NUM_SEATS-1:0] over_thr, r_ages, l_ages;
	logic [NUM_SEATS-1:0] can0, can1, grant_l, grant_r, grants;
	logic [WAIT_W-1:0]    w0 [NUM_SEATS];
	logic [WAIT_W-1:0]    wait_n [NUM_SEATS];
	logic                 is_tick, req_act, rel_act, done_now, rel_grant;
	logic [MEAL_W-1:0]    meal_inc, meal_n;
	logic                 fin_n;

	// A hungry seat may eat when no neighbour eats and no hungry neighbour
	// has out-waited it past the threshold.
	function automatic logic [NUM_SEATS-1:0] can_eat(
		input logic [NUM_SEATS-1:0] hung,
		input logic [NUM_SEATS-1:0] eat,
		input logic [NUM_SEATS-1:0] r_age,
		input logic [NUM_SEATS-1:0] l_age
	);
		logic [NUM_SEATS-1:0] v;
		int l, r;
		for (int i = 0; i < NUM_SEATS; i++) begin
			l = (i == 0) ? NUM_SEATS - 1 : i - 1;
			r = (i == NUM_SEATS - 1) ? 0 : i + 1;
			v[i] = hung[i] && !eat[l] && !eat[r] && !(hung[r] && r_age[i]) &&
				!(hung[l] && l_age[i]);
		end
		return v;
	endfunction

	for (genvar i = 0; i < NUM_SEATS; i++) begin : g_seat
		localparam int L = (i == 0) ? NUM_SEATS - 1 : i - 1;
		localparam int R = (i == NUM_SEATS - 1) ? 0 : i + 1;

		assign seat_oh[i]  = (item.seat == SEAT_W'(i));
		// Seat i is the left neighbour of the event seat when that seat is R.
		assign left_oh[i]  = seat_oh[R];
		assign right_oh[i] = seat_oh[L];

		assign w0[i]       = (req_act && seat_oh[i]) ? '0 : wait_q[i];
		assign over_thr[i] = (w0[i] > cfg.starv_thrsh);
		assign r_ages[i]   = (w0[R] > w0[i]) && over_thr[R];
		assign l_ages[i]   = (w0[L] > w0[i]) && over_thr[L];

		assign wait_n[i] = (is_tick && hung_q[i] && wait_q[i] != WAIT_MAX) ?
			wait_q[i] + 1'b1 : w0[i];
	end

	always_comb begin
		is_tick  = (item.func == FN_TICK);
		req_act  = (item.func == FN_REQUEST) && !fin_q && |(seat_oh & ~hung_q & ~eat_q);
		rel_act  = (item.func == FN_RELEASE) && !fin_q && |(seat_oh & eat_q);
		meal_inc = (meal_q != MEAL_MAX) ? meal_q + 1'b1 : meal_q;
		done_now = (meal_inc >= cfg.meal_limit);

		hung0 = hung_q | (req_act ? seat_oh : '0);
		eat0  = eat_q & ~(rel_act ? seat_oh : '0);
		can0  = can_eat(hung0, eat0, r_ages, l_ages);

		// On a release the left neighbour is served first; the right one sees
		// the result, which matters when the ring has only three seats.
		rel_grant = rel_act && !done_now;
		grant_l   = rel_grant ? (left_oh & can0) : '0;
		hung1     = hung0 & ~grant_l;
		eat1      = eat0 | grant_l;
		can1      = can_eat(hung1, eat1, r_ages, l_ages);
		grant_r   = rel_grant ? (right_oh & can1) : '0;

		grants = req_act ? (seat_oh & can0) : (grant_l | grant_r);
		hung_n = hung0 & ~grants;
		eat_n  = eat0 | grants;
		meal_n = rel_act ? meal_inc : meal_q;
		fin_n  = fin_q | (rel_act && done_now);

		result.grant_mask  = MAX_SEATS'(grants);
		result.done_res    = fin_n;
		result.meals_total = meal_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hung_q <= '0;
			eat_q  <= '0;
			meal_q <= '0;
			fin_q  <= 1'b0;
			for (int i = 0; i < NUM_SEATS; i++) begin
				wait_q[i] <= '0;
			end
		end else if (step) begin
			hung_q <= hung_n;
			eat_q  <= eat_n;
			meal_q <= meal_n;
			fin_q  <= fin_n;
			for (int i = 0; i < NUM_SEATS; i++) begin
				wait_q[i] <= wait_n[i];
			end
		end
	end

endmodule
`default_nettype wire

### rtl/rra_checker.sv
// Port-level checks for the ring resource arbiter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module rra_checker
	import rra_pkg::*;
#(
	parameter int NUM_SEATS = 8
) (
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     out_valid,
	input wire logic     out_ready,
	input wire rra_out_t out_item
);

	// A stalled result item must hold.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result item changed while stalled");

	// Once done, no event may grant a seat.
	a_done_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.done_res |-> out_item.grant_mask == '0)
		else $error("grant issued after done");

	// One event grants at most two seats: the requester, or the neighbours of a released seat.
	a_grant_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $countones(out_item.grant_mask) <= 2)
		else $error("more than two seats granted by one item");

	// No grant for a seat beyond the ring.
	a_grant_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.grant_mask >> NUM_SEATS) == '0)
		else $error("grant for a nonexistent seat");

endmodule

bind ring_resource_arbiter_aging rra_checker #(
	.NUM_SEATS(NUM_SEATS)
) u_rra_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);
`default_nettype wire
